### rtl/satag_pkg.sv
package satag_pkg;

  localparam int unsigned NumSets = 64;
  localparam int unsigned NumWays = 8;
  localparam int unsigned DataW   = 32;
  localparam int unsigned SetW    = (NumSets > 1) ? $clog2(NumSets) : 1;
  localparam int unsigned WayW    = (NumWays > 1) ? $clog2(NumWays) : 1;

  localparam logic ActLookup  = 1'b0;
  localparam logic ActInstall = 1'b1;

  localparam logic PolicyLru = 1'b0;
  localparam logic PolicyLfu = 1'b1;

  localparam int unsigned CntRdAcc   = 0;
  localparam int unsigned CntWrAcc   = 1;
  localparam int unsigned CntRdMiss  = 2;
  localparam int unsigned CntWrMiss  = 3;
  localparam int unsigned CntDirtyEv = 4;
  localparam int unsigned NumCnt     = 5;

  typedef struct packed {
    logic             action;
    logic [DataW-1:0] line_addr;
    logic             write_flag;
  } req_t;

  typedef struct packed {
    logic             hit;
    logic [2:0]       victim_way;
    logic             evicted_valid;
    logic             evicted_dirty;
    logic [DataW-1:0] evicted_tag;
    logic [DataW-1:0] read_accesses;
    logic [DataW-1:0] write_accesses;
    logic [DataW-1:0] read_misses;
    logic [DataW-1:0] write_misses;
    logic [DataW-1:0] dirty_evictions;
  } rsp_t;

  typedef struct packed {
    logic             valid;
    logic             dirty;
    logic [DataW-1:0] tag;
    logic [DataW-1:0] stamp;
    logic [DataW-1:0] count;
  } way_t;

  typedef way_t [NumWays-1:0] set_row_t;

  typedef struct packed {
    logic capture;
    logic mem_rd;
    logic scan;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic scan_last;
    logic rsp_busy;
  } ctrl_sts_t;

  typedef enum logic [1:0] {
    StIdle,
    StRead,
    StScan,
    StCommit
  } state_e;

endpackage

### rtl/satag_ctrl.sv
module satag_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 req_valid_i,
  output logic                 req_ready_o,
  input  satag_pkg::ctrl_sts_t sts_i,
  output satag_pkg::ctrl_cmd_t cmd_o
);
  import satag_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (req_valid_i) begin
          state_d = StRead;
        end
      end
      StRead: begin
        state_d = StScan;
      end
      StScan: begin
        if (sts_i.scan_last) begin
          state_d = StCommit;
        end
      end
      StCommit: begin
        if (!sts_i.rsp_busy) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_comb begin
    req_ready_o = 1'b0;
    cmd_o       = '0;
    case (state_q)
      StIdle: begin
        req_ready_o   = 1'b1;
        cmd_o.capture = req_valid_i;
      end
      StRead: begin
        cmd_o.mem_rd = 1'b1;
      end
      StScan: begin
        cmd_o.scan = 1'b1;
      end
      StCommit: begin
        cmd_o.commit = !sts_i.rsp_busy;
      end
      default: begin
        req_ready_o = 1'b0;
      end
    endcase
  end

endmodule

### rtl/satag_dp.sv
module satag_dp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  satag_pkg::ctrl_cmd_t cmd_i,
  output satag_pkg::ctrl_sts_t sts_o,
  input  logic                 repl_policy_i,
  input  satag_pkg::req_t      req_i,
  output satag_pkg::rsp_t      rsp_o,
  output logic                 rsp_valid_o,
  input  logic                 rsp_ready_i
);
  import satag_pkg::*;

  req_t               req_q;
  logic [SetW-1:0]    set_idx;
  set_row_t           mem_q [NumSets];
  set_row_t           rdata_q;
  logic               row_ok_q;
  logic [NumSets-1:0] row_valid_q;
  set_row_t           row_eff;

  logic [WayW-1:0]    way_q;
  way_t               cur;
  logic               first;
  logic               match;
  logic               better;
  logic               hit_found_q, inv_found_q;
  logic [WayW-1:0]    hit_way_q, inv_way_q, best_way_q;
  logic [DataW-1:0]   best_stamp_q, best_count_q;

  logic               is_inst;
  logic [WayW-1:0]    vway;
  way_t               sel;
  set_row_t           new_row;
  logic               mem_we;
  logic [DataW-1:0]   gstamp_q;
  logic [DataW-1:0]   stat_q [NumCnt];
  logic [DataW-1:0]   stat_d [NumCnt];
  rsp_t               rsp_q, rsp_d;
  logic               rsp_valid_q;

  assign set_idx = req_q.line_addr[SetW-1:0] & SetW'(NumSets - 1);
  assign row_eff = row_ok_q ? rdata_q : '0;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q <= req_i;
    end
    if (cmd_i.mem_rd) begin
      rdata_q  <= mem_q[set_idx];
      row_ok_q <= row_valid_q[set_idx];
    end
    if (cmd_i.commit && mem_we) begin
      mem_q[set_idx] <= new_row;
    end
  end

  assign cur   = row_eff[way_q];
  assign first = (way_q == '0);
  assign match = cur.valid && (cur.tag == req_q.line_addr);

  always_comb begin
    if (repl_policy_i == PolicyLru) begin
      better = cur.stamp < best_stamp_q;
    end else begin
      better = (cur.count < best_count_q) ||
               ((cur.count == best_count_q) && (cur.stamp > best_stamp_q));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      way_q <= '0;
    end else if (cmd_i.mem_rd) begin
      way_q <= '0;
    end else if (cmd_i.scan && !sts_o.scan_last) begin
      way_q <= way_q + WayW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan) begin
      if (first || !hit_found_q) begin
        hit_found_q <= match;
        hit_way_q   <= way_q;
      end
      if (first || !inv_found_q) begin
        inv_found_q <= !cur.valid;
        inv_way_q   <= way_q;
      end
      if (first || better) begin
        best_way_q   <= way_q;
        best_stamp_q <= cur.stamp;
        best_count_q <= cur.count;
      end
    end
  end

  assign sts_o.scan_last = (way_q == WayW'(NumWays - 1));
  assign sts_o.rsp_busy  = rsp_valid_q && !rsp_ready_i;

  assign is_inst = (req_q.action == ActInstall);
  assign mem_we  = is_inst || hit_found_q;

  always_comb begin
    if (is_inst) begin
      vway = inv_found_q ? inv_way_q : best_way_q;
    end else begin
      vway = hit_way_q;
    end
  end

  assign sel = row_eff[vway];

  always_comb begin
    new_row = row_eff;
    if (is_inst) begin
      new_row[vway].valid = 1'b1;
      new_row[vway].dirty = req_q.write_flag;
      new_row[vway].tag   = req_q.line_addr;
      new_row[vway].stamp = gstamp_q;
      new_row[vway].count = DataW'(1);
    end else begin
      new_row[vway].dirty = sel.dirty | req_q.write_flag;
      new_row[vway].stamp = gstamp_q;
      new_row[vway].count = sel.count + DataW'(1);
    end
  end

  always_comb begin
    for (int i = 0; i < NumCnt; i++) begin
      stat_d[i] = stat_q[i];
    end
    if (is_inst) begin
      if (sel.dirty) begin
        stat_d[CntDirtyEv] = stat_q[CntDirtyEv] + DataW'(1);
      end
    end else if (req_q.write_flag) begin
      stat_d[CntWrAcc] = stat_q[CntWrAcc] + DataW'(1);
      if (!hit_found_q) begin
        stat_d[CntWrMiss] = stat_q[CntWrMiss] + DataW'(1);
      end
    end else begin
      stat_d[CntRdAcc] = stat_q[CntRdAcc] + DataW'(1);
      if (!hit_found_q) begin
        stat_d[CntRdMiss] = stat_q[CntRdMiss] + DataW'(1);
      end
    end
  end

  always_comb begin
    rsp_d                 = '0;
    rsp_d.hit             = !is_inst && hit_found_q;
    rsp_d.victim_way      = is_inst ? 3'(vway) : 3'd0;
    rsp_d.evicted_valid   = is_inst && sel.valid;
    rsp_d.evicted_dirty   = is_inst && sel.dirty;
    rsp_d.evicted_tag     = is_inst ? sel.tag : '0;
    rsp_d.read_accesses   = stat_d[CntRdAcc];
    rsp_d.write_accesses  = stat_d[CntWrAcc];
    rsp_d.read_misses     = stat_d[CntRdMiss];
    rsp_d.write_misses    = stat_d[CntWrMiss];
    rsp_d.dirty_evictions = stat_d[CntDirtyEv];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_valid_q <= '0;
      gstamp_q    <= DataW'(1);
      rsp_valid_q <= 1'b0;
      for (int i = 0; i < NumCnt; i++) begin
        stat_q[i] <= '0;
      end
    end else begin
      if (cmd_i.commit) begin
        rsp_valid_q <= 1'b1;
        for (int i = 0; i < NumCnt; i++) begin
          stat_q[i] <= stat_d[i];
        end
        if (mem_we) begin
          row_valid_q[set_idx] <= 1'b1;
          gstamp_q             <= gstamp_q + DataW'(1);
        end
      end else if (rsp_ready_i) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_o       = rsp_q;
  assign rsp_valid_o = rsp_valid_q;

endmodule

### rtl/set_assoc_cache_tag_store_lru_lfu.sv
// A new request is accepted only after the previous one has committed; commit waits while a response is not taken.
// Its response is held in an output register until it is taken.
// The set row is read once, then one way per cycle is compared and ranked for the victim.
// Reset is asynchronous and active low; per-set valid flags make every line read as zero.
// There is no clearing pass, so requests are taken from the first cycle after reset.
module set_assoc_cache_tag_store_lru_lfu (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            req_valid_i,
  output logic            req_ready_o,
  input  satag_pkg::req_t req_i,
  output logic            rsp_valid_o,
  input  logic            rsp_ready_i,
  output satag_pkg::rsp_t rsp_o,
  input  logic            cfg_we_i,
  input  logic            cfg_wdata_i
);
  import satag_pkg::*;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;
  logic      repl_policy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      repl_policy_q <= PolicyLru;
    end else if (cfg_we_i) begin
      repl_policy_q <= cfg_wdata_i;
    end
  end

  satag_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid_i),
    .req_ready_o (req_ready_o),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  satag_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .repl_policy_i (repl_policy_q),
    .req_i         (req_i),
    .rsp_o         (rsp_o),
    .rsp_valid_o   (rsp_valid_o),
    .rsp_ready_i   (rsp_ready_i)
  );

endmodule

### tb/set_assoc_cache_tag_store_lru_lfu_test.sv
module set_assoc_cache_tag_store_lru_lfu_test;
  timeunit 1ns;
  timeprecision 1ps;

  import satag_pkg::*;

  localparam int unsigned Lines = NumSets * NumWays;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned StallAt = 560;
  localparam int unsigned StallLen = 60;

  typedef struct packed {
    logic cfg;
    logic policy;
    req_t req;
    logic typed;
    rsp_t want;
  } dir_row_t;

  localparam rsp_t NoRsp = '0;

  localparam dir_row_t DirectedRows [20] = '{
    '{1'b0, PolicyLru, '{ActLookup, 32'h0000_0000, 1'b0}, 1'b1,
      '{1'b0, 3'd0, 1'b0, 1'b0, 32'h0, 32'd1, 32'd0, 32'd1, 32'd0, 32'd0}},
    '{1'b0, PolicyLru, '{ActInstall, 32'h0000_0000, 1'b0}, 1'b1,
      '{1'b0, 3'd0, 1'b0, 1'b0, 32'h0, 32'd1, 32'd0, 32'd1, 32'd0, 32'd0}},
    '{1'b0, PolicyLru, '{ActLookup, 32'h0000_0000, 1'b1}, 1'b1,
      '{1'b1, 3'd0, 1'b0, 1'b0, 32'h0, 32'd1, 32'd1, 32'd1, 32'd0, 32'd0}},
    '{1'b0, PolicyLru, '{ActLookup, 32'hFFFF_FFFF, 1'b1}, 1'b1,
      '{1'b0, 3'd0, 1'b0, 1'b0, 32'h0, 32'd1, 32'd2, 32'd1, 32'd1, 32'd0}},
    '{1'b0, PolicyLru, '{ActInstall, 32'hFFFF_FFFF, 1'b1}, 1'b1,
      '{1'b0, 3'd0, 1'b0, 1'b0, 32'h0, 32'd1, 32'd2, 32'd1, 32'd1, 32'd0}},
    '{1'b0, PolicyLru, '{ActInstall, 32'h0000_0040, 1'b0}, 1'b0, NoRsp},
    '{1'b0, PolicyLru, '{ActInstall, 32'h0000_0080, 1'b1}, 1'b0, NoRsp},
    '{1'b0, PolicyLru, '{ActInstall, 32'h0000_00C0, 1'b0}, 1'b0, NoRsp},
    '{1'b0, PolicyLru, '{ActInstall, 32'h0000_0100, 1'b1}, 1'b0, NoRsp},
    '{1'b0, PolicyLru, '{ActInstall, 32'h0000_0140, 1'b0}, 1'b0, NoRsp},
    '{1'b0, PolicyLru, '{ActInstall, 32'h0000_0180, 1'b1}, 1'b0, NoRsp},
    '{1'b0, PolicyLru, '{ActInstall, 32'h0000_01C0, 1'b0}, 1'b0, NoRsp},
    '{1'b0, PolicyLru, '{ActLookup, 32'h0000_0040, 1'b0}, 1'b0, NoRsp},
    '{1'b0, PolicyLru, '{ActInstall, 32'h0000_0200, 1'b1}, 1'b0, NoRsp},
    '{1'b0, PolicyLru, '{ActInstall, 32'h0000_0040, 1'b0}, 1'b0, NoRsp},
    '{1'b0, PolicyLru, '{ActLookup, 32'hFFFF_FFC0, 1'b0}, 1'b0, NoRsp},
    '{1'b0, PolicyLru, '{ActLookup, 32'hFFFF_FFFF, 1'b0}, 1'b0, NoRsp},
    '{1'b1, PolicyLfu, '{ActInstall, 32'h0000_0240, 1'b1}, 1'b0, NoRsp},
    '{1'b0, PolicyLfu, '{ActLookup, 32'h0000_0240, 1'b1}, 1'b0, NoRsp},
    '{1'b0, PolicyLfu, '{ActInstall, 32'h0000_0280, 1'b0}, 1'b0, NoRsp}
  };

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic req_valid_i = 1'b0;
  logic req_ready_o;
  req_t req_i = '0;
  logic rsp_valid_o;
  logic rsp_ready_i = 1'b0;
  rsp_t rsp_o;
  logic cfg_we_i = 1'b0;
  logic cfg_wdata_i = 1'b0;

  logic             way_valid [Lines];
  logic             way_dirty [Lines];
  logic [DataW-1:0] way_tag [Lines];
  logic [DataW-1:0] way_stamp [Lines];
  logic [DataW-1:0] way_uses [Lines];
  logic [DataW-1:0] next_stamp;
  logic [DataW-1:0] stat_cnt [NumCnt];
  logic             repl_policy_q;

  rsp_t expected_rsps [$];
  int unsigned mismatches = 0;
  int unsigned snd_idle = 38;
  int unsigned rcv_idle = 47;
  int unsigned rsps_seen = 0;
  int unsigned stall_left = 0;
  logic stalled = 1'b0;
  int unsigned quiet_cycles = 0;
  logic last_hit;

  logic [DataW-SetW-1:0] tag_pool [16];
  logic [SetW-1:0] hot_sets [4];

  set_assoc_cache_tag_store_lru_lfu uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_valid_i(req_valid_i),
    .req_ready_o(req_ready_o),
    .req_i      (req_i),
    .rsp_valid_o(rsp_valid_o),
    .rsp_ready_i(rsp_ready_i),
    .rsp_o      (rsp_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always #6 clk_i = ~clk_i;

  function automatic rsp_t tag_store_access(req_t r);
    rsp_t res;
    int unsigned base;
    int unsigned i;
    int unsigned w;
    int unsigned vw;
    logic found;
    logic [DataW-1:0] least;
    res = '0;
    base = (r.line_addr & (NumSets - 1)) * NumWays;
    if (r.action == ActLookup) begin
      if (r.write_flag) begin
        stat_cnt[CntWrAcc] += 1;
      end else begin
        stat_cnt[CntRdAcc] += 1;
      end
      for (w = 0; w < NumWays; w++) begin
        i = base + w;
        if (!res.hit && way_valid[i] && way_tag[i] == r.line_addr) begin
          way_stamp[i] = next_stamp;
          next_stamp += 1;
          way_uses[i] += 1;
          if (r.write_flag) begin
            way_dirty[i] = 1'b1;
          end
          res.hit = 1'b1;
        end
      end
      if (!res.hit) begin
        if (r.write_flag) begin
          stat_cnt[CntWrMiss] += 1;
        end else begin
          stat_cnt[CntRdMiss] += 1;
        end
      end
    end else begin
      vw = 0;
      found = 1'b0;
      for (w = 0; w < NumWays; w++) begin
        if (!found && !way_valid[base + w]) begin
          vw = w;
          found = 1'b1;
        end
      end
      if (!found && repl_policy_q == PolicyLru) begin
        for (w = 1; w < NumWays; w++) begin
          if (way_stamp[base + w] < way_stamp[base + vw]) begin
            vw = w;
          end
        end
      end else if (!found) begin
        least = way_uses[base];
        for (w = 1; w < NumWays; w++) begin
          if (way_uses[base + w] < least) begin
            least = way_uses[base + w];
          end
        end
        for (w = 0; w < NumWays; w++) begin
          if (way_uses[base + w] == least &&
              (!found || way_stamp[base + w] > way_stamp[base + vw])) begin
            vw = w;
            found = 1'b1;
          end
        end
      end
      i = base + vw;
      res.victim_way = 3'(vw);
      res.evicted_valid = way_valid[i];
      res.evicted_dirty = way_dirty[i];
      res.evicted_tag = way_tag[i];
      if (way_dirty[i]) begin
        stat_cnt[CntDirtyEv] += 1;
      end
      way_stamp[i] = next_stamp;
      next_stamp += 1;
      way_tag[i] = r.line_addr;
      way_valid[i] = 1'b1;
      way_uses[i] = 1;
      way_dirty[i] = r.write_flag;
    end
    res.read_accesses = stat_cnt[CntRdAcc];
    res.write_accesses = stat_cnt[CntWrAcc];
    res.read_misses = stat_cnt[CntRdMiss];
    res.write_misses = stat_cnt[CntWrMiss];
    res.dirty_evictions = stat_cnt[CntDirtyEv];
    return res;
  endfunction

  task automatic flag_mismatch(input string what, input logic [DataW-1:0] got,
                               input logic [DataW-1:0] want);
    $display("%0t mismatch in %s: got %0h, expected %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  task automatic check_rsp(input rsp_t got);
    rsp_t want;
    if (expected_rsps.size() == 0) begin
      flag_mismatch("response with none pending, read_accesses", got.read_accesses, '0);
    end else begin
      want = expected_rsps.pop_front();
      if (got.hit !== want.hit) flag_mismatch("hit", DataW'(got.hit), DataW'(want.hit));
      if (got.victim_way !== want.victim_way) begin
        flag_mismatch("victim_way", DataW'(got.victim_way), DataW'(want.victim_way));
      end
      if (got.evicted_valid !== want.evicted_valid) begin
        flag_mismatch("evicted_valid", DataW'(got.evicted_valid), DataW'(want.evicted_valid));
      end
      if (got.evicted_dirty !== want.evicted_dirty) begin
        flag_mismatch("evicted_dirty", DataW'(got.evicted_dirty), DataW'(want.evicted_dirty));
      end
      if (got.evicted_tag !== want.evicted_tag) begin
        flag_mismatch("evicted_tag", got.evicted_tag, want.evicted_tag);
      end
      if (got.read_accesses !== want.read_accesses) begin
        flag_mismatch("read_accesses", got.read_accesses, want.read_accesses);
      end
      if (got.write_accesses !== want.write_accesses) begin
        flag_mismatch("write_accesses", got.write_accesses, want.write_accesses);
      end
      if (got.read_misses !== want.read_misses) begin
        flag_mismatch("read_misses", got.read_misses, want.read_misses);
      end
      if (got.write_misses !== want.write_misses) begin
        flag_mismatch("write_misses", got.write_misses, want.write_misses);
      end
      if (got.dirty_evictions !== want.dirty_evictions) begin
        flag_mismatch("dirty_evictions", got.dirty_evictions, want.dirty_evictions);
      end
    end
  endtask

  task automatic issue(input req_t r, input logic typed, input rsp_t want);
    rsp_t pred;
    if ($urandom_range(99) < snd_idle) begin
      req_valid_i <= 1'b0;
      repeat ($urandom_range(12, 1)) @(posedge clk_i);
    end
    req_valid_i <= 1'b1;
    req_i <= r;
    @(posedge clk_i);
    while (!req_ready_o) @(posedge clk_i);
    pred = tag_store_access(r);
    expected_rsps.insert(expected_rsps.size(), typed ? want : pred);
    last_hit = pred.hit;
  endtask

  task automatic write_policy(input logic v);
    req_valid_i <= 1'b0;
    while (expected_rsps.size() != 0) @(posedge clk_i);
    repeat (NumWays + 4) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    repl_policy_q = v;
  endtask

  // Most traffic is a lookup followed by an install on a miss, over a few busy sets.
  task automatic run_random(input int unsigned n);
    int unsigned sent;
    int unsigned kind;
    logic [SetW-1:0] s;
    logic [DataW-1:0] a;
    logic wr;
    sent = 0;
    while (sent < n) begin
      kind = $urandom_range(99);
      if ($urandom_range(99) < 5) begin
        a = $urandom;
      end else begin
        s = ($urandom_range(99) < 70) ? hot_sets[$urandom_range(3)]
                                      : SetW'($urandom_range(NumSets - 1));
        a = {tag_pool[$urandom_range(15)], s};
      end
      wr = 1'($urandom_range(1));
      if (kind < 85) begin
        issue('{ActLookup, a, wr}, 1'b0, NoRsp);
        sent++;
        if (kind < 75 && !last_hit) begin
          issue('{ActInstall, a, 1'($urandom_range(1))}, 1'b0, NoRsp);
          sent++;
        end
      end else begin
        issue('{ActInstall, a, wr}, 1'b0, NoRsp);
        sent++;
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && rsp_valid_o && rsp_ready_i) begin
      check_rsp(rsp_o);
      rsps_seen <= rsps_seen + 1;
    end
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      rsp_ready_i <= 1'b0;
    end else if (rsps_seen == StallAt && !stalled) begin
      stalled <= 1'b1;
      stall_left <= StallLen;
      rsp_ready_i <= 1'b0;
    end else begin
      rsp_ready_i <= ($urandom_range(99) >= rcv_idle);
    end
  end

  always @(posedge clk_i) begin
    if ((req_valid_i && req_ready_o) || (rsp_valid_o && rsp_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int unsigned k;
    for (k = 0; k < Lines; k++) begin
      way_valid[k] = 1'b0;
      way_dirty[k] = 1'b0;
      way_tag[k] = '0;
      way_stamp[k] = '0;
      way_uses[k] = '0;
    end
    for (k = 0; k < NumCnt; k++) begin
      stat_cnt[k] = '0;
    end
    next_stamp = 1;
    repl_policy_q = PolicyLru;
    for (k = 0; k < 16; k++) begin
      tag_pool[k] = (DataW - SetW)'($urandom);
    end
    for (k = 0; k < 4; k++) begin
      hot_sets[k] = SetW'($urandom_range(NumSets - 1));
    end

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_policy(PolicyLru);
    for (k = 0; k < 20; k++) begin
      if (DirectedRows[k].cfg) begin
        write_policy(DirectedRows[k].policy);
      end
      issue(DirectedRows[k].req, DirectedRows[k].typed, DirectedRows[k].want);
    end

    write_policy(PolicyLru);
    run_random(250);

    snd_idle = 47;
    rcv_idle <= 38;
    write_policy(PolicyLfu);
    run_random(250);

    snd_idle = 0;
    rcv_idle <= 0;
    write_policy(PolicyLru);
    run_random(125);
    write_policy(PolicyLfu);
    run_random(125);

    req_valid_i <= 1'b0;
    while (expected_rsps.size() != 0) @(posedge clk_i);
    repeat (3 * NumWays) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
